[rtl/eatr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eatr_pkg: shared types and constants for the Euler angle to rotation block
// Holds the fixed-point formats, the series divisor and reciprocal tables,
// the axis codes and the Q1.14 product and saturation helpers.
// ----------------------------------------------------------------------------
package eatr_pkg;

    localparam int ANGLE_W  = 16;
    localparam int FRAC_W   = 14;
    localparam int CODE_W   = 7;
    localparam int SC_ITER  = 8;
    // two setup stages, three per series term, one rounding stage
    localparam int SC_LAT   = 3 * SC_ITER + 3;
    localparam int MX_LAT   = 3;
    localparam int LATENCY  = 1 + SC_LAT + MX_LAT;

    localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
    localparam logic [31:0] Q30_ONE     = 32'h4000_0000;

    localparam int REL_BIT = 6;

    typedef logic [ANGLE_W-1:0]       t_angle;
    typedef logic signed [15:0]       t_q;
    typedef t_q [8:0]                 t_mat;
    typedef logic [1:0]               t_axis;
    typedef logic [8:0]               t_div;

    localparam t_axis AXIS_X    = 2'd0;
    localparam t_axis AXIS_Y    = 2'd1;
    localparam t_axis AXIS_Z    = 2'd2;
    localparam t_axis AXIS_NONE = 2'd3;

    localparam t_q Q_ONE = 16'sd16384;

    // divisors of the sine and cosine series terms
    localparam t_div DIV_S [1:8] = '{9'd6, 9'd20, 9'd42, 9'd72,
                                     9'd110, 9'd156, 9'd210, 9'd272};
    localparam t_div DIV_C [1:8] = '{9'd2, 9'd12, 9'd30, 9'd56,
                                     9'd90, 9'd132, 9'd182, 9'd240};

    // floor(2^32 / d): quotient estimate is exact or one low
    localparam logic [31:0] RCP_S [1:8] = '{
        32'((64'd1 << 32) / 64'd6),   32'((64'd1 << 32) / 64'd20),
        32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd72),
        32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd156),
        32'((64'd1 << 32) / 64'd210), 32'((64'd1 << 32) / 64'd272)};
    localparam logic [31:0] RCP_C [1:8] = '{
        32'((64'd1 << 32) / 64'd2),   32'((64'd1 << 32) / 64'd12),
        32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd56),
        32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd132),
        32'((64'd1 << 32) / 64'd182), 32'((64'd1 << 32) / 64'd240)};

    typedef struct packed {
        logic  valid;
        logic  bad;
        logic  rep;
        t_axis ax_i;
        t_axis ax_j;
    } t_side;

    // product of two Q1.14 values, floor shift
    function automatic t_q mulq(input t_q a, input t_q b);
        logic signed [31:0] p;
        p = a * b;
        return 16'(p >>> FRAC_W);
    endfunction

    function automatic t_q satq(input logic signed [17:0] v);
        if (v > 18'sd16384) begin
            return Q_ONE;
        end else if (v < -18'sd16384) begin
            return -Q_ONE;
        end
        return 16'(v);
    endfunction

endpackage
`default_nettype wire

[rtl/eatr_sincos.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eatr_sincos: pipelined sine and cosine of a binary angle
// Octant-free series in Q2.30 over eight terms, one term per three stages,
// then clamp, round to Q1.14 and quadrant mapping.
// ----------------------------------------------------------------------------
module eatr_sincos (
    input  wire logic            i_clk,
    input  wire eatr_pkg::t_angle i_angle,
    output eatr_pkg::t_q         o_sin,
    output eatr_pkg::t_q         o_cos
);
    import eatr_pkg::*;

    logic [44:0] w_xprod;
    logic [30:0] r_x;
    t_axis       r_quad;
    logic [61:0] w_xsq;

    logic [31:0]        r_ts [0:SC_ITER];
    logic [31:0]        r_tc [0:SC_ITER];
    logic signed [34:0] r_s  [0:SC_ITER];
    logic signed [34:0] r_c  [0:SC_ITER];
    logic [31:0]        r_x2 [0:SC_ITER];
    t_axis              r_qd [0:SC_ITER];

    assign w_xprod = 45'(i_angle[ANGLE_W-3:0]) * 45'(PI_HALF_Q30)
                   + 45'(1 << (ANGLE_W - 3));
    assign w_xsq   = 62'(r_x) * 62'(r_x);

    always_ff @(posedge i_clk) begin
        r_x     <= w_xprod[44:14];
        r_quad  <= i_angle[ANGLE_W-1:ANGLE_W-2];
        r_ts[0] <= 32'(r_x);
        r_tc[0] <= Q30_ONE;
        r_s[0]  <= $signed(35'(r_x));
        r_c[0]  <= $signed(35'(Q30_ONE));
        r_x2[0] <= w_xsq[61:30];
        r_qd[0] <= r_quad;
    end

    genvar n;
    generate
        for (n = 1; n <= SC_ITER; n++) begin : g_term
            logic [63:0]        w_ms, w_mc, w_rs, w_rc;
            logic [41:0]        w_rem_s, w_rem_c;
            logic [31:0]        w_ts, w_tc;
            logic [31:0]        r_pa_s, r_pa_c, r_pb_s, r_pb_c, r_qs, r_qc;
            logic [31:0]        r_x2a, r_x2b;
            logic signed [34:0] r_sa, r_ca, r_sb, r_cb;
            t_axis              r_qa, r_qb;

            assign w_ms = 64'(r_ts[n-1]) * 64'(r_x2[n-1]);
            assign w_mc = 64'(r_tc[n-1]) * 64'(r_x2[n-1]);
            assign w_rs = 64'(r_pa_s) * 64'(RCP_S[n]);
            assign w_rc = 64'(r_pa_c) * 64'(RCP_C[n]);
            assign w_rem_s = 42'(r_pb_s) - 42'(r_qs) * 42'(DIV_S[n]);
            assign w_rem_c = 42'(r_pb_c) - 42'(r_qc) * 42'(DIV_C[n]);
            // correct the one-low reciprocal estimate
            assign w_ts = r_qs + 32'(w_rem_s >= 42'(DIV_S[n]));
            assign w_tc = r_qc + 32'(w_rem_c >= 42'(DIV_C[n]));

            always_ff @(posedge i_clk) begin
                r_pa_s <= w_ms[61:30];
                r_pa_c <= w_mc[61:30];
                r_x2a  <= r_x2[n-1];
                r_sa   <= r_s[n-1];
                r_ca   <= r_c[n-1];
                r_qa   <= r_qd[n-1];

                r_qs   <= w_rs[63:32];
                r_qc   <= w_rc[63:32];
                r_pb_s <= r_pa_s;
                r_pb_c <= r_pa_c;
                r_x2b  <= r_x2a;
                r_sb   <= r_sa;
                r_cb   <= r_ca;
                r_qb   <= r_qa;

                r_ts[n] <= w_ts;
                r_tc[n] <= w_tc;
                r_x2[n] <= r_x2b;
                r_qd[n] <= r_qb;
                if (n % 2 == 1) begin
                    r_s[n] <= r_sb - $signed(35'(w_ts));
                    r_c[n] <= r_cb - $signed(35'(w_tc));
                end else begin
                    r_s[n] <= r_sb + $signed(35'(w_ts));
                    r_c[n] <= r_cb + $signed(35'(w_tc));
                end
            end
        end
    endgenerate

    logic [30:0] w_sclamp, w_cclamp;
    logic [31:0] w_sround, w_cround;
    t_q          w_smag, w_cmag;
    t_q          n_sin, n_cos;

    always_comb begin
        if (r_s[SC_ITER][34]) begin
            w_sclamp = '0;
        end else if (r_s[SC_ITER] > $signed(35'(Q30_ONE))) begin
            w_sclamp = 31'(Q30_ONE);
        end else begin
            w_sclamp = r_s[SC_ITER][30:0];
        end
        if (r_c[SC_ITER][34]) begin
            w_cclamp = '0;
        end else if (r_c[SC_ITER] > $signed(35'(Q30_ONE))) begin
            w_cclamp = 31'(Q30_ONE);
        end else begin
            w_cclamp = r_c[SC_ITER][30:0];
        end
        w_sround = 32'(w_sclamp) + 32'(1 << (29 - FRAC_W));
        w_cround = 32'(w_cclamp) + 32'(1 << (29 - FRAC_W));
        w_smag   = 16'(w_sround >> (30 - FRAC_W));
        w_cmag   = 16'(w_cround >> (30 - FRAC_W));
        case (r_qd[SC_ITER])
            2'd0: begin
                n_sin = w_smag;
                n_cos = w_cmag;
            end
            2'd1: begin
                n_sin = w_cmag;
                n_cos = -w_smag;
            end
            2'd2: begin
                n_sin = -w_smag;
                n_cos = -w_cmag;
            end
            default: begin
                n_sin = -w_cmag;
                n_cos = w_smag;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_sin <= n_sin;
        o_cos <= n_cos;
    end

endmodule
`default_nettype wire

[rtl/eatr_matrix.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eatr_matrix: rotation matrix assembly from sines and cosines
// Pairwise products, triple products, then sums, saturation and placement
// of the nine entries by axis role, over three register stages.
// ----------------------------------------------------------------------------
module eatr_matrix (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire eatr_pkg::t_side i_side,
    input  wire eatr_pkg::t_q   i_sa,
    input  wire eatr_pkg::t_q   i_ca,
    input  wire eatr_pkg::t_q   i_sb,
    input  wire eatr_pkg::t_q   i_cb,
    input  wire eatr_pkg::t_q   i_sc,
    input  wire eatr_pkg::t_q   i_cc,
    output eatr_pkg::t_side     o_side,
    output eatr_pkg::t_mat      o_m
);
    import eatr_pkg::*;

    t_side r_side1, r_side2;
    t_q    r1_cc_ca, r1_cc_sa, r1_sc_ca, r1_sc_sa;
    t_q    r1_sbsc, r1_sbcc, r1_sasb, r1_ncasb, r1_cacb, r1_cbsc, r1_cbcc;
    t_q    r1_cbsa;
    t_q    r1_sb, r1_cb;

    always_ff @(posedge i_clk) begin
        r1_cc_ca <= mulq(i_cc, i_ca);
        r1_cc_sa <= mulq(i_cc, i_sa);
        r1_sc_ca <= mulq(i_sc, i_ca);
        r1_sc_sa <= mulq(i_sc, i_sa);
        r1_sbsc  <= mulq(i_sb, i_sc);
        r1_sbcc  <= mulq(i_sb, i_cc);
        r1_sasb  <= mulq(i_sa, i_sb);
        r1_ncasb <= mulq(-i_ca, i_sb);
        r1_cacb  <= mulq(i_ca, i_cb);
        r1_cbsc  <= mulq(i_cb, i_sc);
        r1_cbcc  <= mulq(i_cb, i_cc);
        r1_cbsa  <= mulq(i_cb, i_sa);
        r1_sb    <= i_sb;
        r1_cb    <= i_cb;
    end

    t_q w_f1, w_f2;
    t_q r2_ta, r2_tb, r2_tc, r2_td;
    t_q r2_cc_ca, r2_cc_sa, r2_sc_ca, r2_sc_sa;
    t_q r2_sbsc, r2_sbcc, r2_sasb, r2_ncasb, r2_cacb, r2_cbsc, r2_cbcc;
    t_q r2_cbsa;
    t_q r2_sb, r2_cb;

    assign w_f1 = r_side1.rep ? -r1_cb : r1_sb;
    assign w_f2 = r_side1.rep ? r1_cb : r1_sb;

    always_ff @(posedge i_clk) begin
        r2_ta    <= mulq(w_f1, r1_sc_sa);
        r2_tb    <= mulq(w_f1, r1_cc_sa);
        r2_tc    <= mulq(w_f2, r1_sc_ca);
        r2_td    <= mulq(w_f2, r1_cc_ca);
        r2_cc_ca <= r1_cc_ca;
        r2_cc_sa <= r1_cc_sa;
        r2_sc_ca <= r1_sc_ca;
        r2_sc_sa <= r1_sc_sa;
        r2_sbsc  <= r1_sbsc;
        r2_sbcc  <= r1_sbcc;
        r2_sasb  <= r1_sasb;
        r2_ncasb <= r1_ncasb;
        r2_cacb  <= r1_cacb;
        r2_cbsc  <= r1_cbsc;
        r2_cbcc  <= r1_cbcc;
        r2_cbsa  <= r1_cbsa;
        r2_sb    <= r1_sb;
        r2_cb    <= r1_cb;
    end

    // entries by role: index 3*row_role + col_role, roles i, j, k
    t_q    w_f [0:8];
    t_mat  n_m;
    logic [1:0] w_rr, w_cr;

    always_comb begin
        w_f[4] = satq(18'(r2_ta) + 18'(r2_cc_ca));
        w_f[5] = satq(18'(r2_tb) - 18'(r2_sc_ca));
        if (r_side2.rep) begin
            w_f[0] = satq(18'(r2_cb));
            w_f[1] = satq(18'(r2_sbsc));
            w_f[2] = satq(18'(r2_sbcc));
            w_f[3] = satq(18'(r2_sasb));
            w_f[6] = satq(18'(r2_ncasb));
            w_f[7] = satq(18'(r2_tc) + 18'(r2_cc_sa));
            w_f[8] = satq(18'(r2_td) - 18'(r2_sc_sa));
        end else begin
            w_f[0] = satq(18'(r2_cacb));
            w_f[1] = satq(18'(r2_tc) - 18'(r2_cc_sa));
            w_f[2] = satq(18'(r2_td) + 18'(r2_sc_sa));
            w_f[3] = satq(18'(r2_cbsa));
            w_f[6] = satq(-18'(r2_sb));
            w_f[7] = satq(18'(r2_cbsc));
            w_f[8] = satq(18'(r2_cbcc));
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                w_rr = (2'(r) == r_side2.ax_i) ? 2'd0 : (2'(r) == r_side2.ax_j) ? 2'd1 : 2'd2;
                w_cr = (2'(c) == r_side2.ax_i) ? 2'd0 : (2'(c) == r_side2.ax_j) ? 2'd1 : 2'd2;
                n_m[r*3+c] = r_side2.bad ? '0 : w_f[4'(w_rr) * 4'd3 + 4'(w_cr)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_m <= n_m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side1 <= '0;
            r_side2 <= '0;
            o_side  <= '0;
        end else begin
            r_side1 <= i_side;
            r_side2 <= r_side1;
            o_side  <= r_side2;
        end
    end

endmodule
`default_nettype wire

[rtl/euler_angles_to_rotation_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_top: Euler angles to 3x3 rotation matrix
// Decodes the axis order, runs three sine/cosine pipelines and assembles
// the Q1.14 matrix with a bad-order flag.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  command   start / busy          i_angle_first/second/third, i_order_code
//  result    o_valid (strobe)      o_m_rR_cC (9 x Q1.14), o_bad_order
//
//  One command is taken every cycle; busy is held low.
//  A result strobes once its command has passed one decode stage,
//  27 stages of sine/cosine series (three per term) and three matrix stages.
//  Synchronous reset clears only the side-band registers along the pipe.
//  The receiver cannot stall; results leave on their strobe.
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic signed [15:0]  i_angle_first,
    input  wire logic signed [15:0]  i_angle_second,
    input  wire logic signed [15:0]  i_angle_third,
    input  wire logic [6:0]          i_order_code,
    output logic                     o_valid,
    output logic signed [15:0]       o_m_r0_c0,
    output logic signed [15:0]       o_m_r0_c1,
    output logic signed [15:0]       o_m_r0_c2,
    output logic signed [15:0]       o_m_r1_c0,
    output logic signed [15:0]       o_m_r1_c1,
    output logic signed [15:0]       o_m_r1_c2,
    output logic signed [15:0]       o_m_r2_c0,
    output logic signed [15:0]       o_m_r2_c1,
    output logic signed [15:0]       o_m_r2_c2,
    output logic                     o_bad_order
);
    import eatr_pkg::*;

    assign busy = 1'b0;

    t_axis  w_i, w_j, w_k;
    t_angle w_a, w_c;
    logic   w_bad, w_odd;
    t_side  n_side, r_side;
    t_angle r_a, r_b, r_c;

    always_comb begin
        if (i_order_code[REL_BIT]) begin
            w_i = i_order_code[1:0];
            w_k = i_order_code[5:4];
            w_a = i_angle_third;
            w_c = i_angle_first;
        end else begin
            w_i = i_order_code[5:4];
            w_k = i_order_code[1:0];
            w_a = i_angle_first;
            w_c = i_angle_third;
        end
        w_j   = i_order_code[3:2];
        w_bad = (w_i == AXIS_NONE) || (w_j == AXIS_NONE) || (w_k == AXIS_NONE)
             || (w_i == w_j);
        w_odd = ((w_i == AXIS_X) && (w_j == AXIS_Z))
             || ((w_i == AXIS_Y) && (w_j == AXIS_X))
             || ((w_i == AXIS_Z) && (w_j == AXIS_Y));
        n_side.valid = start && !busy;
        n_side.bad   = w_bad;
        n_side.rep   = (w_i == w_k);
        n_side.ax_i  = w_i;
        n_side.ax_j  = w_j;
    end

    always_ff @(posedge i_clk) begin
        // negate all angles for an odd axis permutation
        r_a <= w_odd ? -w_a : w_a;
        r_b <= w_odd ? -t_angle'(i_angle_second) : t_angle'(i_angle_second);
        r_c <= w_odd ? -w_c : w_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else begin
            r_side <= n_side;
        end
    end

    // side band delay matching the sine/cosine pipes
    t_side r_dl [0:SC_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < SC_LAT; t++) begin
                r_dl[t] <= '0;
            end
        end else begin
            r_dl[0] <= r_side;
            for (int t = 1; t < SC_LAT; t++) begin
                r_dl[t] <= r_dl[t-1];
            end
        end
    end

    t_q w_sa, w_ca, w_sb, w_cb, w_sc, w_cc;

    eatr_sincos u_sc_a (.i_clk(i_clk), .i_angle(r_a), .o_sin(w_sa), .o_cos(w_ca));
    eatr_sincos u_sc_b (.i_clk(i_clk), .i_angle(r_b), .o_sin(w_sb), .o_cos(w_cb));
    eatr_sincos u_sc_c (.i_clk(i_clk), .i_angle(r_c), .o_sin(w_sc), .o_cos(w_cc));

    t_side w_oside;
    t_mat  w_m;

    eatr_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (r_dl[SC_LAT-1]),
        .i_sa    (w_sa),
        .i_ca    (w_ca),
        .i_sb    (w_sb),
        .i_cb    (w_cb),
        .i_sc    (w_sc),
        .i_cc    (w_cc),
        .o_side  (w_oside),
        .o_m     (w_m)
    );

    assign o_valid     = w_oside.valid;
    assign o_bad_order = w_oside.bad;
    assign o_m_r0_c0   = w_m[0];
    assign o_m_r0_c1   = w_m[1];
    assign o_m_r0_c2   = w_m[2];
    assign o_m_r1_c0   = w_m[3];
    assign o_m_r1_c1   = w_m[4];
    assign o_m_r1_c2   = w_m[5];
    assign o_m_r2_c0   = w_m[6];
    assign o_m_r2_c1   = w_m[7];
    assign o_m_r2_c2   = w_m[8];

endmodule
`default_nettype wire

[rtl/eatr_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eatr_checker: port-level checks for the rotation block
// Watches commands and result strobes at the top level ports.
// ----------------------------------------------------------------------------
module eatr_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic [6:0]         i_order_code,
    input wire logic               o_valid,
    input wire logic               o_bad_order,
    input wire logic signed [15:0] o_m_r0_c0,
    input wire logic signed [15:0] o_m_r1_c1,
    input wire logic signed [15:0] o_m_r2_c2
);
    import eatr_pkg::*;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_result_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result strobe without a command");

    a_bad_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(start && (i_order_code[3:2] == 2'b11), LATENCY)
        |-> o_bad_order)
        else $error("invalid axis code not flagged");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_order
        |-> (o_m_r0_c0 == 16'sd0) && (o_m_r1_c1 == 16'sd0) && (o_m_r2_c2 == 16'sd0))
        else $error("bad order result not zero");

endmodule

bind euler_angles_to_rotation_top eatr_checker u_eatr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_order_code (i_order_code),
    .o_valid      (o_valid),
    .o_bad_order  (o_bad_order),
    .o_m_r0_c0    (o_m_r0_c0),
    .o_m_r1_c1    (o_m_r1_c1),
    .o_m_r2_c2    (o_m_r2_c2)
);
`default_nettype wire
